// ===== rtl/chg_pkg.sv =====
// Package for the gift-wrap convex hull block.
// Holds the point type, the orientation result struct, shared constants and the point_less ordering.
// No dependencies.
package chg_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int MAX_POINTS_DEF = 64;

  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  typedef struct packed {
    logic done;
    logic left;
  } orient_res_t;

  function automatic logic point_less(input point_t a, input point_t b);
    return (a.x < b.x) || ((a.x == b.x) && (a.y < b.y));
  endfunction

endpackage

// ===== rtl/convex_hull_gift_wrap_top.sv =====
// Gift-wrap (Jarvis march) convex hull: top level with point memory and sequencer.
// Uses chg_orient for the cross-product test. Depends on chg_pkg.
// Points load at one transaction per cycle into a MAX_POINTS-entry memory
// (extra points are dropped). The transaction marked last_point stalls input
// while the hull is computed: the start search reads each stored point in
// turn, and each hull vertex takes a pass over the n stored points through
// the single memory read port, with the one shared multiplier forming both
// cross-product terms. Vertices leave through an output register, so the
// wrap continues while a vertex waits to be taken. After the final vertex
// input reopens for the next set; at most MAX_POINTS vertices are emitted,
// the last flagged truncated if the wrap did not close.
module convex_hull_gift_wrap_top #(
  parameter int MAX_POINTS = chg_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [chg_pkg::COORD_W-1:0]  in_point_x,
  input  logic signed [chg_pkg::COORD_W-1:0]  in_point_y,
  input  logic                                in_last_point,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [chg_pkg::COORD_W-1:0]  out_hull_x,
  output logic signed [chg_pkg::COORD_W-1:0]  out_hull_y,
  output logic                                out_hull_last,
  output logic                                out_hull_truncated
);
  import chg_pkg::*;

  localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  typedef enum logic [3:0] {
    S_LOAD,
    S_ST_RD,
    S_ST_CMP,
    S_W_RD0,
    S_W_C0,
    S_W_RD,
    S_W_GET,
    S_W_OR,
    S_W_END
  } state_t;

  point_t              mem [MAX_POINTS];
  point_t              rd_data_r;
  logic [ADDR_W-1:0]   rd_addr;
  logic                wr_en;
  point_t              wr_data;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    emit_r, emit_nxt;
  point_t              start_r, start_nxt;
  point_t              p_r, p_nxt;
  point_t              cand_r, cand_nxt;
  point_t              s_r, s_nxt;
  logic                out_valid_r, out_valid_nxt;
  point_t              out_pt_r, out_pt_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_trunc_r, out_trunc_nxt;

  logic                in_fire, out_free;
  logic [CNT_W-1:0]    idx_inc, emit_inc;
  point_t              start_new;
  logic                closed, fin;
  logic                orient_start;
  orient_res_t         ores;

  chg_orient u_orient (
    .clk   (clk),
    .rst_n (rst_n),
    .start (orient_start),
    .p     (p_r),
    .c     (cand_r),
    .s     (rd_data_r),
    .res   (ores)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[ADDR_W-1:0]] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    in_fire = in_valid && !in_stall;
    out_free = !out_valid_r || !out_stall;
    wr_en = in_fire && (count_r < CNT_W'(MAX_POINTS));
    wr_data = '{y: in_point_y, x: in_point_x};
    idx_inc = idx_r + CNT_W'(1);
    emit_inc = emit_r + CNT_W'(1);
    start_new = ((idx_r == '0) || point_less(rd_data_r, start_r)) ? rd_data_r : start_r;
    closed = (cand_r == start_r);
    fin = closed || (emit_inc == CNT_W'(MAX_POINTS));
    rd_addr = (state_r == S_W_RD0) ? '0 : idx_r[ADDR_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    n_nxt = n_r;
    idx_nxt = idx_r;
    emit_nxt = emit_r;
    start_nxt = start_r;
    p_nxt = p_r;
    cand_nxt = cand_r;
    s_nxt = s_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_pt_nxt = out_pt_r;
    out_last_nxt = out_last_r;
    out_trunc_nxt = out_trunc_r;
    orient_start = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        if (in_fire) begin
          if (wr_en) begin
            count_nxt = count_r + CNT_W'(1);
          end
          if (in_last_point) begin
            n_nxt = wr_en ? (count_r + CNT_W'(1)) : count_r;
            idx_nxt = '0;
            state_nxt = S_ST_RD;
          end
        end
      end
      S_ST_RD: state_nxt = S_ST_CMP;
      S_ST_CMP: begin
        start_nxt = start_new;
        idx_nxt = idx_inc;
        if (idx_inc == n_r) begin
          p_nxt = start_new;
          emit_nxt = '0;
          state_nxt = S_W_RD0;
        end else begin
          state_nxt = S_ST_RD;
        end
      end
      S_W_RD0: state_nxt = S_W_C0;
      S_W_C0: begin
        cand_nxt = rd_data_r;
        idx_nxt = CNT_W'(1);
        state_nxt = (n_r == CNT_W'(1)) ? S_W_END : S_W_RD;
      end
      S_W_RD: state_nxt = S_W_GET;
      S_W_GET: begin
        s_nxt = rd_data_r;
        if (cand_r == p_r) begin
          cand_nxt = rd_data_r;
          idx_nxt = idx_inc;
          state_nxt = (idx_inc == n_r) ? S_W_END : S_W_RD;
        end else begin
          orient_start = 1'b1;
          state_nxt = S_W_OR;
        end
      end
      S_W_OR: begin
        if (ores.done) begin
          if (ores.left) begin
            cand_nxt = s_r;
          end
          idx_nxt = idx_inc;
          state_nxt = (idx_inc == n_r) ? S_W_END : S_W_RD;
        end
      end
      S_W_END: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pt_nxt = p_r;
          out_last_nxt = fin;
          out_trunc_nxt = fin && !closed;
          p_nxt = cand_r;
          emit_nxt = emit_inc;
          if (fin) begin
            count_nxt = '0;
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_W_RD0;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r <= n_nxt;
    idx_r <= idx_nxt;
    emit_r <= emit_nxt;
    start_r <= start_nxt;
    p_r <= p_nxt;
    cand_r <= cand_nxt;
    s_r <= s_nxt;
    out_pt_r <= out_pt_nxt;
    out_last_r <= out_last_nxt;
    out_trunc_r <= out_trunc_nxt;
  end

  assign in_stall = (state_r != S_LOAD);
  assign out_valid = out_valid_r;
  assign out_hull_x = out_pt_r.x;
  assign out_hull_y = out_pt_r.y;
  assign out_hull_last = out_last_r;
  assign out_hull_truncated = out_trunc_r;

endmodule

// ===== rtl/chg_orient.sv =====
// Orientation test for the hull block: is s strictly left of the ray p to c?
// One shared 17x17 multiplier forms both cross-product terms in turn.
// Depends on chg_pkg.
module chg_orient (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  chg_pkg::point_t     p,
  input  chg_pkg::point_t     c,
  input  chg_pkg::point_t     s,
  output chg_pkg::orient_res_t res
);
  import chg_pkg::*;

  typedef enum logic [1:0] {
    O_IDLE,
    O_MUL_A,
    O_MUL_B,
    O_CMP
  } ostate_t;

  ostate_t                   state_r, state_nxt;
  logic signed [DIFF_W-1:0]  ux_r, uy_r, vx_r, vy_r;
  logic signed [DIFF_W-1:0]  ux_nxt, uy_nxt, vx_nxt, vy_nxt;
  logic signed [PROD_W-1:0]  prod_a_r, prod_a_nxt, prod_b_r, prod_b_nxt;
  orient_res_t               res_r, res_nxt;
  logic signed [DIFF_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0]  mul_w;
  logic signed [PROD_W:0]    diff_w;

  always_comb begin
    mul_a = (state_r == O_MUL_A) ? ux_r : uy_r;
    mul_b = (state_r == O_MUL_A) ? vy_r : vx_r;
    mul_w = mul_a * mul_b;
    diff_w = $signed({prod_a_r[PROD_W-1], prod_a_r}) -
             $signed({prod_b_r[PROD_W-1], prod_b_r});
  end

  always_comb begin
    state_nxt = state_r;
    ux_nxt = ux_r;
    uy_nxt = uy_r;
    vx_nxt = vx_r;
    vy_nxt = vy_r;
    prod_a_nxt = prod_a_r;
    prod_b_nxt = prod_b_r;
    res_nxt = '{done: 1'b0, left: res_r.left};
    unique case (state_r)
      O_IDLE: begin
        if (start) begin
          ux_nxt = $signed({c.x[COORD_W-1], c.x}) - $signed({p.x[COORD_W-1], p.x});
          uy_nxt = $signed({c.y[COORD_W-1], c.y}) - $signed({p.y[COORD_W-1], p.y});
          vx_nxt = $signed({s.x[COORD_W-1], s.x}) - $signed({p.x[COORD_W-1], p.x});
          vy_nxt = $signed({s.y[COORD_W-1], s.y}) - $signed({p.y[COORD_W-1], p.y});
          state_nxt = O_MUL_A;
        end
      end
      O_MUL_A: begin
        prod_a_nxt = mul_w;
        state_nxt = O_MUL_B;
      end
      O_MUL_B: begin
        prod_b_nxt = mul_w;
        state_nxt = O_CMP;
      end
      O_CMP: begin
        res_nxt.done = 1'b1;
        res_nxt.left = !diff_w[PROD_W] && (diff_w != '0);
        state_nxt = O_IDLE;
      end
      default: state_nxt = O_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= O_IDLE;
      res_r <= '0;
    end else begin
      state_r <= state_nxt;
      res_r <= res_nxt;
    end
    ux_r <= ux_nxt;
    uy_r <= uy_nxt;
    vx_r <= vx_nxt;
    vy_r <= vy_nxt;
    prod_a_r <= prod_a_nxt;
    prod_b_r <= prod_b_nxt;
  end

  assign res = res_r;

endmodule

// ===== rtl/chg_checker.sv =====
// Port-level checker for the gift-wrap convex hull block, with its bind.
// Watches only the top level's ports. Depends on chg_pkg.
module chg_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                in_last_point,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [chg_pkg::COORD_W-1:0]  out_hull_x,
  input logic signed [chg_pkg::COORD_W-1:0]  out_hull_y,
  input logic                                out_hull_last,
  input logic                                out_hull_truncated
);
  import chg_pkg::*;

  // A stalled output transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hull_x) &&
      $stable(out_hull_y) && $stable(out_hull_last) && $stable(out_hull_truncated))
    else $error("output payload changed while stalled");

  // The last point of a set closes the input while the hull is computed.
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_point |=> in_stall)
    else $error("input not stalled after last point");

  // A truncated wrap is only reported on the final vertex.
  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hull_truncated |-> out_hull_last)
    else $error("truncation flag without final vertex");

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind convex_hull_gift_wrap_top chg_checker u_chg_checker (.*);
